// ===== design/apr_pkg.sv =====
`timescale 1ns / 1ps
package apr_pkg;

  localparam int SectorBytesDef = 2048;
  localparam int SettleReadsDef = 4;
  localparam logic [31:0] PollLimitRst = 32'd50000000;
  localparam logic [20:0] MaxSectors = 21'h1fffff;
  localparam int BurstMax = 8;

  localparam logic [7:0] ST_CHK = 8'h01;
  localparam logic [7:0] ST_DRQ = 8'h08;
  localparam logic [7:0] ST_BSY = 8'h80;
  localparam logic [15:0] CMD_PACKET = 16'h00a0;
  localparam logic [15:0] SEL_MASTER = 16'h00a0;
  localparam logic [15:0] PKT_READ_WORD = 16'h2030;

  localparam logic [2:0] REG_ALTST = 3'd0;
  localparam logic [2:0] REG_DATA = 3'd1;
  localparam logic [2:0] REG_FEAT = 3'd2;
  localparam logic [2:0] REG_SECCNT = 3'd3;
  localparam logic [2:0] REG_CNTLO = 3'd4;
  localparam logic [2:0] REG_CNTHI = 3'd5;
  localparam logic [2:0] REG_SELECT = 3'd6;
  localparam logic [2:0] REG_CMD = 3'd7;

  localparam logic [2:0] E_OK = 3'd0;
  localparam logic [2:0] E_ARG = 3'd1;
  localparam logic [2:0] E_IDLE = 3'd2;
  localparam logic [2:0] E_PACKET = 3'd3;
  localparam logic [2:0] E_DATA = 3'd4;
  localparam logic [2:0] E_COUNT = 3'd5;
  localparam logic [2:0] E_END = 3'd6;
  localparam logic [2:0] E_CHECK = 3'd7;

  localparam logic [2:0] CFG_POLL_LIMIT = 3'd0;

  typedef struct packed {
    logic        bus_request;
    logic        bus_write;
    logic [2:0]  bus_register;
    logic [15:0] bus_write_data;
    logic        data_valid;
    logic [15:0] data_word;
    logic        done_res;
    logic [2:0]  error_code;
    logic [7:0]  fail_status;
    logic [7:0]  fail_error;
  } res_t;

  typedef struct packed {
    logic [3:0]              cnt;
    res_t [BurstMax-1:0]     list;
  } burst_t;

  function automatic res_t mk_rd(input logic [2:0] r);
    res_t x;
    x = '0;
    x.bus_request = 1'b1;
    x.bus_register = r;
    return x;
  endfunction

  function automatic res_t mk_wr(input logic [2:0] r, input logic [15:0] v);
    res_t x;
    x = '0;
    x.bus_request = 1'b1;
    x.bus_write = 1'b1;
    x.bus_register = r;
    x.bus_write_data = v;
    return x;
  endfunction

endpackage

// ===== design/apr_core.sv =====
`timescale 1ns / 1ps
module apr_core import apr_pkg::*; #(
  parameter int SECTOR_BYTES = SectorBytesDef,
  parameter int SETTLE_READS = SettleReadsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic        operation,
  input  logic [23:0] start_fad,
  input  logic [20:0] sector_count,
  input  logic [15:0] read_data,
  input  logic [31:0] poll_limit,
  output burst_t      burst
);

  localparam int BR_W = $clog2(longint'(MaxSectors) * longint'(SECTOR_BYTES) + 1);
  localparam logic [15:0] SB16 = 16'(SECTOR_BYTES);
  localparam logic [2:0] SETTLE3 = 3'(SETTLE_READS);

  typedef enum logic [12:0] {
    PH_IDLE        = 13'b0000000000001,
    PH_WAIT_IDLE   = 13'b0000000000010,
    PH_SETTLE_PKT  = 13'b0000000000100,
    PH_WAIT_PKT    = 13'b0000000001000,
    PH_SETTLE_DATA = 13'b0000000010000,
    PH_WAIT_DATA   = 13'b0000000100000,
    PH_READ_BCHI   = 13'b0000001000000,
    PH_READ_BCLO   = 13'b0000010000000,
    PH_DATA        = 13'b0000100000000,
    PH_WAIT_END    = 13'b0001000000000,
    PH_CHECK       = 13'b0010000000000,
    PH_FAIL_ST     = 13'b0100000000000,
    PH_FAIL_ER     = 13'b1000000000000
  } phase_t;

  phase_t            ph_r, ph_nxt;
  logic [31:0]       poll_r, poll_nxt;
  logic [2:0]        settle_r, settle_nxt;
  logic [23:0]       addr_r, addr_nxt;
  logic [20:0]       sec_r, sec_nxt;
  logic [BR_W-1:0]   bytes_r, bytes_nxt;
  logic [14:0]       words_r, words_nxt;
  logic [7:0]        cnthi_r, cnthi_nxt;
  logic [2:0]        pfail_r, pfail_nxt;
  logic [7:0]        fst_r, fst_nxt;

  logic [7:0]  st;
  logic [31:0] lim;
  logic        expired;
  logic [15:0] n16;
  logic [14:0] words_dec;
  logic [2:0]  settle_dec;
  logic [3:0]  k;

  always_comb begin
    st = read_data[7:0];
    lim = (poll_limit == 32'd0) ? 32'd1 : poll_limit;
    expired = ({1'b0, poll_r} + 33'd1) >= {1'b0, lim};
    n16 = {cnthi_r, st};
    words_dec = (words_r != 15'd0) ? words_r - 15'd1 : words_r;
    settle_dec = (settle_r != 3'd0) ? settle_r - 3'd1 : settle_r;

    ph_nxt = ph_r;
    poll_nxt = poll_r;
    settle_nxt = settle_r;
    addr_nxt = addr_r;
    sec_nxt = sec_r;
    bytes_nxt = bytes_r;
    words_nxt = words_r;
    cnthi_nxt = cnthi_r;
    pfail_nxt = pfail_r;
    fst_nxt = fst_r;
    burst = '0;
    k = 4'd0;

    if (operation == 1'b0) begin
      if (ph_r == PH_IDLE) begin
        addr_nxt = start_fad;
        sec_nxt = sector_count;
        if (sector_count == 21'd0 || sector_count > MaxSectors) begin
          bytes_nxt = '0;
          pfail_nxt = E_ARG;
          ph_nxt = PH_FAIL_ST;
          burst.list[0] = mk_rd(REG_ALTST);
          k = 4'd1;
        end else begin
          bytes_nxt = BR_W'(sector_count) * BR_W'(SECTOR_BYTES);
          poll_nxt = '0;
          ph_nxt = PH_WAIT_IDLE;
          burst.list[0] = mk_wr(REG_SELECT, SEL_MASTER);
          burst.list[1] = mk_rd(REG_ALTST);
          k = 4'd2;
        end
      end
    end else begin
      case (ph_r)
        PH_WAIT_IDLE: begin
          if ((st & (ST_BSY | ST_DRQ)) == 8'h00) begin
            burst.list[0] = mk_wr(REG_FEAT, 16'h0000);
            burst.list[1] = mk_wr(REG_SECCNT, 16'h0000);
            burst.list[2] = mk_wr(REG_CNTLO, {8'h00, SB16[7:0]});
            burst.list[3] = mk_wr(REG_CNTHI, {8'h00, SB16[15:8]});
            burst.list[4] = mk_wr(REG_CMD, CMD_PACKET);
            burst.list[5] = mk_rd(REG_ALTST);
            k = 4'd6;
            poll_nxt = '0;
            if (SETTLE_READS > 0) begin
              settle_nxt = SETTLE3;
              ph_nxt = PH_SETTLE_PKT;
            end else begin
              ph_nxt = PH_WAIT_PKT;
            end
          end else if (expired) begin
            poll_nxt = poll_r + 32'd1;
            pfail_nxt = E_IDLE;
            ph_nxt = PH_FAIL_ST;
            burst.list[0] = mk_rd(REG_ALTST);
            k = 4'd1;
          end else begin
            poll_nxt = poll_r + 32'd1;
            burst.list[0] = mk_rd(REG_ALTST);
            k = 4'd1;
          end
        end
        PH_SETTLE_PKT, PH_SETTLE_DATA: begin
          settle_nxt = settle_dec;
          if (settle_dec == 3'd0) begin
            ph_nxt = (ph_r == PH_SETTLE_PKT) ? PH_WAIT_PKT : PH_WAIT_DATA;
          end
          burst.list[0] = mk_rd(REG_ALTST);
          k = 4'd1;
        end
        PH_WAIT_PKT: begin
          if ((st & ST_BSY) != 8'h00) begin
            poll_nxt = poll_r + 32'd1;
            if (expired) begin
              pfail_nxt = E_PACKET;
              ph_nxt = PH_FAIL_ST;
            end
            burst.list[0] = mk_rd(REG_ALTST);
            k = 4'd1;
          end else if ((st & ST_DRQ) != 8'h00) begin
            burst.list[0] = mk_wr(REG_DATA, PKT_READ_WORD);
            burst.list[1] = mk_wr(REG_DATA, {addr_r[15:8], addr_r[23:16]});
            burst.list[2] = mk_wr(REG_DATA, {8'h00, addr_r[7:0]});
            burst.list[3] = mk_wr(REG_DATA, 16'h0000);
            burst.list[4] = mk_wr(REG_DATA, {sec_r[15:8], 3'b000, sec_r[20:16]});
            burst.list[5] = mk_wr(REG_DATA, {8'h00, sec_r[7:0]});
            burst.list[6] = mk_rd(REG_ALTST);
            k = 4'd7;
            poll_nxt = '0;
            if (SETTLE_READS > 0) begin
              settle_nxt = SETTLE3;
              ph_nxt = PH_SETTLE_DATA;
            end else begin
              ph_nxt = PH_WAIT_DATA;
            end
          end else begin
            pfail_nxt = E_PACKET;
            ph_nxt = PH_FAIL_ST;
            burst.list[0] = mk_rd(REG_ALTST);
            k = 4'd1;
          end
        end
        PH_WAIT_DATA: begin
          if ((st & ST_BSY) != 8'h00) begin
            poll_nxt = poll_r + 32'd1;
            if (expired) begin
              pfail_nxt = E_DATA;
              ph_nxt = PH_FAIL_ST;
            end
            burst.list[0] = mk_rd(REG_ALTST);
          end else if ((st & ST_DRQ) != 8'h00) begin
            ph_nxt = PH_READ_BCHI;
            burst.list[0] = mk_rd(REG_CNTHI);
          end else begin
            poll_nxt = '0;
            ph_nxt = PH_WAIT_END;
            burst.list[0] = mk_rd(REG_ALTST);
          end
          k = 4'd1;
        end
        PH_READ_BCHI: begin
          cnthi_nxt = st;
          ph_nxt = PH_READ_BCLO;
          burst.list[0] = mk_rd(REG_CNTLO);
          k = 4'd1;
        end
        PH_READ_BCLO: begin
          if (n16 == 16'd0 || n16[0] || BR_W'(n16) > bytes_r) begin
            pfail_nxt = E_COUNT;
            ph_nxt = PH_FAIL_ST;
            burst.list[0] = mk_rd(REG_ALTST);
          end else begin
            bytes_nxt = bytes_r - BR_W'(n16);
            words_nxt = n16[15:1];
            ph_nxt = PH_DATA;
            burst.list[0] = mk_rd(REG_DATA);
          end
          k = 4'd1;
        end
        PH_DATA: begin
          burst.list[0] = '0;
          burst.list[0].data_valid = 1'b1;
          burst.list[0].data_word = read_data;
          words_nxt = words_dec;
          if (words_dec != 15'd0) begin
            burst.list[1] = mk_rd(REG_DATA);
          end else if (bytes_r != '0) begin
            poll_nxt = '0;
            if (SETTLE_READS > 0) begin
              settle_nxt = SETTLE3;
              ph_nxt = PH_SETTLE_DATA;
            end else begin
              ph_nxt = PH_WAIT_DATA;
            end
            burst.list[1] = mk_rd(REG_ALTST);
          end else begin
            poll_nxt = '0;
            ph_nxt = PH_WAIT_END;
            burst.list[1] = mk_rd(REG_ALTST);
          end
          k = 4'd2;
        end
        PH_WAIT_END: begin
          if ((st & (ST_BSY | ST_DRQ)) == 8'h00) begin
            ph_nxt = PH_CHECK;
            burst.list[0] = mk_rd(REG_CMD);
          end else begin
            poll_nxt = poll_r + 32'd1;
            if (expired) begin
              pfail_nxt = E_END;
              ph_nxt = PH_FAIL_ST;
            end
            burst.list[0] = mk_rd(REG_ALTST);
          end
          k = 4'd1;
        end
        PH_CHECK: begin
          if ((st & ST_CHK) != 8'h00 || bytes_r != '0) begin
            pfail_nxt = ((st & ST_CHK) != 8'h00) ? E_CHECK : E_DATA;
            ph_nxt = PH_FAIL_ST;
            burst.list[0] = mk_rd(REG_ALTST);
          end else begin
            ph_nxt = PH_IDLE;
            burst.list[0] = '0;
            burst.list[0].done_res = 1'b1;
            burst.list[0].error_code = E_OK;
          end
          k = 4'd1;
        end
        PH_FAIL_ST: begin
          fst_nxt = st;
          ph_nxt = PH_FAIL_ER;
          burst.list[0] = mk_rd(REG_FEAT);
          k = 4'd1;
        end
        PH_FAIL_ER: begin
          ph_nxt = PH_IDLE;
          burst.list[0] = '0;
          burst.list[0].done_res = 1'b1;
          burst.list[0].error_code = pfail_r;
          burst.list[0].fail_status = fst_r;
          burst.list[0].fail_error = st;
          k = 4'd1;
        end
        default: begin
          ph_nxt = PH_IDLE;
        end
      endcase
    end
    burst.cnt = k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
      poll_r <= '0;
      settle_r <= '0;
      addr_r <= '0;
      sec_r <= '0;
      bytes_r <= '0;
      words_r <= '0;
      cnthi_r <= '0;
      pfail_r <= '0;
      fst_r <= '0;
    end else if (go) begin
      ph_r <= ph_nxt;
      poll_r <= poll_nxt;
      settle_r <= settle_nxt;
      addr_r <= addr_nxt;
      sec_r <= sec_nxt;
      bytes_r <= bytes_nxt;
      words_r <= words_nxt;
      cnthi_r <= cnthi_nxt;
      pfail_r <= pfail_nxt;
      fst_r <= fst_nxt;
    end
  end

endmodule

// ===== design/apr_emit.sv =====
`timescale 1ns / 1ps
module apr_emit import apr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load,
  input  burst_t burst,
  output logic   empty,
  output logic   out_valid,
  input  logic   out_stall,
  output res_t   out_res,
  output logic   out_last
);

  res_t [BurstMax-1:0] buf_r;
  logic [3:0]          rem_r;
  logic [2:0]          ptr_r;
  logic                ov_r;
  res_t                res_r;
  logic                last_r;
  logic                free;
  logic                drain;

  // The buffer counts as empty once its last entry moves out this cycle.
  assign free = !ov_r || !out_stall;
  assign drain = free && (rem_r != 4'd0);
  assign empty = (rem_r == 4'd0) || (rem_r == 4'd1 && free);
  assign out_valid = ov_r;
  assign out_res = res_r;
  assign out_last = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      ptr_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (free) begin
        ov_r <= (rem_r != 4'd0);
      end
      if (load && empty) begin
        rem_r <= burst.cnt;
        ptr_r <= '0;
      end else if (drain) begin
        ptr_r <= ptr_r + 3'd1;
        rem_r <= rem_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && empty) begin
      buf_r <= burst.list;
    end
    if (drain) begin
      res_r <= buf_r[ptr_r];
      last_r <= (rem_r == 4'd1);
    end
  end

endmodule

// ===== design/atapi_pio_packet_read_host_top.sv =====
`timescale 1ns / 1ps
// Host side of a polled ATA packet read. A start transfer (operation 0) carries
// a frame address and sector count; the block then emits, one per output
// transfer, the register accesses to issue (select, status polls, PIO setup,
// PACKET, the six packet words, byte-count reads, data reads), every sector
// data word, and a final done result with an error code. Each bus read must be
// answered by one response transfer (operation 1) carrying the read value.
// An input transfer passes through an input register and is decoded
// combinationally into a burst of zero to seven results held in a small
// result buffer; the buffer drains one result per cycle through the output
// register. The next input transfer is decoded in the cycle in which the last
// buffered result moves to the output register; an item's first result passes
// the input register, result buffer and output register. Responses that cause
// a single result (status polls, settle reads, byte-count reads) sustain one
// per cycle; a data word response causes two results (the word and the next
// read), so the next response waits until the read moves out. Output stalls
// hold the buffer, and the input once the last buffered result is waiting.
// poll_limit sits at byte address 0 of the APB port (0 acts as 1).
module atapi_pio_packet_read_host_top import apr_pkg::*; #(
  parameter int SECTOR_BYTES = SectorBytesDef,
  parameter int SETTLE_READS = SettleReadsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [23:0] in_start_fad,
  input  logic [20:0] in_sector_count,
  input  logic [15:0] in_read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_bus_request,
  output logic        out_bus_write,
  output logic [2:0]  out_bus_register,
  output logic [15:0] out_bus_write_data,
  output logic        out_data_valid,
  output logic [15:0] out_data_word,
  output logic        out_done_res,
  output logic [2:0]  out_error_code,
  output logic [7:0]  out_fail_status,
  output logic [7:0]  out_fail_error,
  output logic        out_last_of_run
);

  logic [31:0] limit_r;
  logic        iv_r;
  logic        op_r;
  logic [23:0] fad_r;
  logic [20:0] cnt_r;
  logic [15:0] rd_r;
  logic        empty;
  logic        go;
  burst_t      burst;
  res_t        res;

  // Configuration: one register, written on the APB access phase.
  assign pready = 1'b1;
  assign prdata = (paddr == {CFG_POLL_LIMIT[0], 2'b00}) ? limit_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= PollLimitRst;
    end else if (psel && penable && pwrite && paddr == {CFG_POLL_LIMIT[0], 2'b00}) begin
      limit_r <= pwdata;
    end
  end

  // Decode the held transfer once the result buffer has drained.
  assign go = iv_r && empty;
  assign in_stall = iv_r && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (!in_stall) begin
      iv_r <= in_valid;
    end
  end

  // Hold payload while the input is stalled.
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      op_r <= in_operation;
      fad_r <= in_start_fad;
      cnt_r <= in_sector_count;
      rd_r <= in_read_data;
    end
  end

  apr_core #(
    .SECTOR_BYTES(SECTOR_BYTES),
    .SETTLE_READS(SETTLE_READS)
  ) u_core (
    .clk(clk),
    .rst_n(rst_n),
    .go(go),
    .operation(op_r),
    .start_fad(fad_r),
    .sector_count(cnt_r),
    .read_data(rd_r),
    .poll_limit(limit_r),
    .burst(burst)
  );

  apr_emit u_emit (
    .clk(clk),
    .rst_n(rst_n),
    .load(go),
    .burst(burst),
    .empty(empty),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res(res),
    .out_last(out_last_of_run)
  );

  assign out_bus_request = res.bus_request;
  assign out_bus_write = res.bus_write;
  assign out_bus_register = res.bus_register;
  assign out_bus_write_data = res.bus_write_data;
  assign out_data_valid = res.data_valid;
  assign out_data_word = res.data_word;
  assign out_done_res = res.done_res;
  assign out_error_code = res.error_code;
  assign out_fail_status = res.fail_status;
  assign out_fail_error = res.fail_error;

endmodule
